// ----- design/lgs_pkg.sv -----
// Shared types and constants for the Life generation stencil.
package lgs_pkg;

   localparam int CSR_W   = 6;
   localparam int COUNT_W = 4;

   localparam logic [CSR_W-1:0]   GRID_SIZE_RESET = 6'd32;
   localparam logic [COUNT_W-1:0] BIRTH_COUNT     = 4'd3;
   localparam logic [COUNT_W-1:0] SURVIVE_COUNT   = 4'd2;

   // One column of the two line stores.
   typedef struct packed {
      logic mid;
      logic up;
   } col_pair_type;

   // One column of the 3x3 window, oldest row on top.
   typedef struct packed {
      logic row_bot;
      logic row_mid;
      logic row_top;
   } window_col_type;

   // [0] left, [1] center, [2] right.
   typedef window_col_type [2:0] window_type;

   typedef struct packed {
      logic left_dead;
      logic right_dead;
      logic top_dead;
   } border_type;

   typedef struct packed {
      window_type win;
      border_type border;
      logic       last;
   } job_type;

   typedef struct packed {
      logic               next_alive;
      logic [COUNT_W-1:0] live_neighbours;
      logic               frame_last;
   } result_type;

endpackage

// ----- design/lgs_if.sv -----
// Stream interfaces for the cell input and the result output channels.
interface lgs_req_if;
   logic valid;
   logic ready;
   logic cell_alive;

   modport source (output valid, output cell_alive, input ready);
   modport sink (input valid, input cell_alive, output ready);
endinterface

interface lgs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        next_alive;
   logic [lgs_pkg::COUNT_W-1:0] live_neighbours;
   logic                        frame_last;

   modport source (output valid, output next_alive, output live_neighbours,
                   output frame_last, input ready);
   modport sink (input valid, input next_alive, input live_neighbours,
                 input frame_last, output ready);
endinterface

// ----- design/lgs_line_cell.sv -----
// One column cell of the line store chain: holds two rows of one column.
module lgs_line_cell (
   input  logic                  clock,
   input  logic                  shift_en,
   input  logic                  entry_sel,
   input  lgs_pkg::col_pair_type from_next,
   input  lgs_pkg::col_pair_type entry_data,
   output lgs_pkg::col_pair_type pair_q
);
   import lgs_pkg::*;

   col_pair_type pair_ff;
   col_pair_type pair_in;

   // The entry cell takes the new column; the rest pass toward cell 0.
   assign pair_in = entry_sel ? entry_data : from_next;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         pair_ff <= pair_in;
      end
   end

   assign pair_q = pair_ff;

endmodule

// ----- design/lgs_rule_stage.sv -----
// Neighbor count, B3/S23 rule and registered result output stage.
module lgs_rule_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  lgs_pkg::job_type    job,
   output logic                job_take,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output lgs_pkg::result_type result
);
   import lgs_pkg::*;

   logic               rsp_valid_ff;
   result_type         result_ff;
   logic [7:0]         nb;
   logic [COUNT_W-1:0] count_in;
   logic               alive_in;
   window_type         w;
   border_type         b;

   assign w = job.win;
   assign b = job.border;

   always_comb begin
      nb[0] = w[0].row_top & ~b.left_dead & ~b.top_dead;
      nb[1] = w[0].row_mid & ~b.left_dead;
      nb[2] = w[0].row_bot & ~b.left_dead;
      nb[3] = w[1].row_top & ~b.top_dead;
      nb[4] = w[1].row_bot;
      nb[5] = w[2].row_top & ~b.right_dead & ~b.top_dead;
      nb[6] = w[2].row_mid & ~b.right_dead;
      nb[7] = w[2].row_bot & ~b.right_dead;
      count_in = COUNT_W'($countones(nb));
      alive_in = (count_in == BIRTH_COUNT) || (w[1].row_mid && (count_in == SURVIVE_COUNT));
   end

   assign job_take = job_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (job_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (job_take) begin
         result_ff.next_alive      <= alive_in;
         result_ff.live_neighbours <= count_in;
         result_ff.frame_last      <= job.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// ----- design/life_generation_stencil.sv -----
// Life generation stencil (B3/S23, dead border): cells in raster order, next states out.
// Throughput: one cell per cycle while results are taken; after the last cell of a frame req
// ready drops while a dead row is pushed through the column cell chain to flush row N-1.
// Reset (synchronous): clears position and pipeline valids, grid size back to 32 (clamped
// to MAX_SIZE); the column cells are not cleared, stale rows are masked as dead.
module life_generation_stencil #(
   parameter int MAX_SIZE = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   lgs_req_if.sink                     req_chan,
   lgs_rsp_if.source                   rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [lgs_pkg::CSR_W-1:0]   csr_wr_data
);
   import lgs_pkg::*;

   localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int SIDE_W = $clog2(MAX_SIZE + 1);
   localparam int ROW_W  = $clog2(MAX_SIZE + 2);
   localparam logic [SIDE_W-1:0] SIDE_RESET =
      (int'(GRID_SIZE_RESET) > MAX_SIZE) ? SIDE_W'(MAX_SIZE) : SIDE_W'(GRID_SIZE_RESET);

   logic [SIDE_W-1:0] side_ff;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              s1_valid_ff;
   job_type           job_ff, job_in;

   logic [IDX_W-1:0]  tap_idx;
   logic [ROW_W-1:0]  side_plus1;
   logic              flushing;
   logic              s1_free;
   logic              job_take;
   logic              push;
   logic              push_bit;
   logic              col_zero;
   logic              produce;
   logic              frame_end;
   col_pair_type      entry_pair;
   col_pair_type      cell_q     [MAX_SIZE];
   col_pair_type      chain_next [MAX_SIZE];
   window_col_type    new_col;
   result_type        result;
   logic              rsp_valid;

   assign tap_idx    = IDX_W'(side_ff - SIDE_W'(1));
   assign side_plus1 = ROW_W'(side_ff) + ROW_W'(1);
   // rows N and N+1 are a virtual dead row that drains the last results
   assign flushing   = (row_ff >= ROW_W'(side_ff));
   assign s1_free    = !s1_valid_ff || job_take;
   assign req_chan.ready = s1_free && !flushing;
   assign push       = s1_free && (flushing || req_chan.valid);
   assign push_bit   = flushing ? 1'b0 : req_chan.cell_alive;

   // column cell chain: a column enters at cell N-1 and reaches cell 0 N-1 transfers later
   assign entry_pair.mid = push_bit;
   assign entry_pair.up  = cell_q[0].mid;

   for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
      if (k == MAX_SIZE - 1) begin : g_last
         assign chain_next[k] = '0;
      end else begin : g_mid
         assign chain_next[k] = cell_q[k+1];
      end

      lgs_line_cell u_cell (
         .clock      (clock),
         .shift_en   (push),
         .entry_sel  (tap_idx == IDX_W'(k)),
         .from_next  (chain_next[k]),
         .entry_data (entry_pair),
         .pair_q     (cell_q[k])
      );
   end

   always_comb begin
      new_col.row_top = cell_q[0].up;
      new_col.row_mid = cell_q[0].mid;
      new_col.row_bot = push_bit;

      col_zero  = (col_ff == '0);
      // at column 0 the result is the last cell of the row two above the input row, right side dead
      produce   = col_zero ? (row_ff >= ROW_W'(2)) : (row_ff != '0);
      frame_end = col_zero && (row_ff == side_plus1);

      job_in.win[0]            = job_ff.win[1];
      job_in.win[1]            = job_ff.win[2];
      job_in.win[2]            = new_col;
      job_in.border.left_dead  = (col_ff == IDX_W'(1)) || (col_zero && side_ff == SIDE_W'(1));
      job_in.border.right_dead = col_zero;
      job_in.border.top_dead   = col_zero ? (row_ff == ROW_W'(2)) : (row_ff == ROW_W'(1));
      job_in.last              = frame_end;

      if (frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (col_ff == tap_idx) begin
         col_in = '0;
         row_in = row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + IDX_W'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_RESET;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_wr_data == '0) begin
               side_ff <= SIDE_W'(1);
            end else if (32'(csr_wr_data) > 32'(MAX_SIZE)) begin
               side_ff <= SIDE_W'(MAX_SIZE);
            end else begin
               side_ff <= SIDE_W'(csr_wr_data);
            end
            col_ff <= '0;
            row_ff <= '0;
         end else if (push) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end

         if (push) begin
            s1_valid_ff <= produce;
         end else if (job_take) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff <= job_in;
      end
   end

   lgs_rule_stage u_rule (
      .clock     (clock),
      .reset     (reset),
      .job_valid (s1_valid_ff),
      .job       (job_ff),
      .job_take  (job_take),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .result    (result)
   );

   assign rsp_chan.valid           = rsp_valid;
   assign rsp_chan.next_alive      = result.next_alive;
   assign rsp_chan.live_neighbours = result.live_neighbours;
   assign rsp_chan.frame_last      = result.frame_last;

`ifndef SYNTHESIS
   a_window_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !job_take) |=> $stable(job_ff.win))
      else $error("window shifted while its result was still waiting");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= tap_idx)
      else $error("column position beyond grid side");

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (push && frame_end) |=> (row_ff == '0 && col_ff == '0))
      else $error("position did not wrap after the frame flush");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the Life generation stencil: directed patterns and random cell streams.
module testbench;
   import lgs_pkg::*;

   localparam int MAX_SIDE       = 32;
   localparam int SETTLE_CYCLES  = MAX_SIDE + 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 40;
   localparam int MAX_SIZE_ITEMS = 2 * MAX_SIDE + 2;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   lgs_req_if req_bus ();
   lgs_rsp_if rsp_bus ();

   life_generation_stencil dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predictor state: current frame and input position
   int         grid_side;
   int         in_row;
   int         in_col;
   int         emitted;
   logic       frame_cells [0:MAX_SIDE-1][0:MAX_SIDE-1];
   result_type pending_states [$];

   int mismatches  = 0;
   int idle_cycles = 0;
   bit no_idle     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int effective_side(input logic [CSR_W-1:0] size);
      if (size == '0) return 1;
      if (size > MAX_SIDE) return MAX_SIDE;
      return int'(size);
   endfunction

   // outside the grid counts as dead
   function automatic logic cell_at(input int r, input int c);
      if (r < 0 || c < 0 || r >= grid_side || c >= grid_side) return 1'b0;
      return frame_cells[r][c];
   endfunction

   task automatic push_next_state(input int r, input int c);
      result_type res;
      int cnt = 0;
      for (int dr = -1; dr <= 1; dr++)
         for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) cnt += cell_at(r + dr, c + dc);
      res.live_neighbours = COUNT_W'(cnt);
      res.next_alive      = (res.live_neighbours == BIRTH_COUNT) ||
                            (cell_at(r, c) && res.live_neighbours == SURVIVE_COUNT);
      res.frame_last      = (r == grid_side - 1) && (c == grid_side - 1);
      pending_states.push_back(res);
      emitted++;
   endtask

   task automatic restart_frame();
      in_row  = 0;
      in_col  = 0;
      emitted = 0;
   endtask

   // a cell's result is known once its lower right neighbor has arrived
   task automatic take_cell(input logic alive);
      if (in_col == 0 && in_row >= 2) push_next_state(in_row - 2, grid_side - 1);
      frame_cells[in_row][in_col] = alive;
      if (in_col >= 1 && in_row >= 1) push_next_state(in_row - 1, in_col - 1);
      if (in_row == grid_side - 1 && in_col == grid_side - 1) begin
         for (int idx = emitted; idx < grid_side * grid_side; idx++)
            push_next_state(idx / grid_side, idx % grid_side);
         restart_frame();
      end else if (in_col + 1 >= grid_side) begin
         in_col = 0;
         in_row++;
      end else begin
         in_col++;
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatches < 40) $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   task automatic send_cell(input logic alive);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cell_alive <= alive;
      do @(posedge clock); while (!req_bus.ready);
      take_cell(alive);
   endtask

   task automatic send_pattern(input logic [63:0] bits, input int count);
      for (int i = 0; i < count; i++) send_cell(bits[i]);
   endtask

   task automatic wait_drained(input int settle);
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_states.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // a write also restarts the frame at cell (0,0)
   task automatic write_grid_size(input logic [CSR_W-1:0] size);
      wait_drained(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      grid_side = effective_side(size);
      restart_frame();
   endtask

   // default size 32: the second row releases the first results
   task automatic test_reset_size();
      for (int i = 0; i < 36; i++) send_cell($urandom_range(0, 1) == 1);
   endtask

   task automatic test_directed_patterns();
      write_grid_size(6'd0);
      send_pattern(64'h1, 1);
      send_pattern(64'h0, 1);
      write_grid_size(6'd1);
      send_pattern(64'h1, 1);
      write_grid_size(6'd2);
      send_pattern(64'hF, 4);
      write_grid_size(6'd3);
      send_pattern(64'h1FF, 9);
      // vertical blinker in the middle column
      send_pattern(64'h092, 9);
   endtask

   task automatic test_random_frames();
      int               sent = 0;
      int               frame = 0;
      int               cells;
      int               density;
      logic [CSR_W-1:0] size;
      while (sent < RANDOM_ITEMS) begin
         if (frame == 0 || $urandom_range(0, 2) != 0) begin
            size = ($urandom_range(0, 9) == 0) ? '0 : CSR_W'($urandom_range(1, 8));
            write_grid_size(size);
         end
         no_idle = ($urandom_range(0, 3) == 0);
         density = $urandom_range(0, 100);
         cells   = grid_side * grid_side - (in_row * grid_side + in_col);
         // broken frame: cut short, the next write restarts it
         if (cells > 1 && $urandom_range(0, 4) == 0) cells = $urandom_range(1, cells - 1);
         if (cells > RANDOM_ITEMS - sent) cells = RANDOM_ITEMS - sent;
         for (int k = 0; k < cells; k++) begin
            if ((frame == 0 && k == cells / 2) || $urandom_range(0, 39) == 0)
               wait_drained(0);
            send_cell($urandom_range(1, 100) <= density);
            sent++;
         end
         frame++;
      end
      no_idle = 1'b0;
   endtask

   // 63 clamps to the largest grid; past row 1 so a right-edge result comes out
   task automatic test_max_size();
      write_grid_size(6'd63);
      for (int i = 0; i < MAX_SIZE_ITEMS; i++) send_cell($urandom_range(0, 1) == 1);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.cell_alive <= 1'b0;
      frame_cells = '{default: 1'b0};
      grid_side   = effective_side(GRID_SIZE_RESET);
      restart_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_directed_patterns();
      test_random_frames();
      test_max_size();

      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("life_generation_stencil: match");
      end else begin
         $display("life_generation_stencil: mismatch");
      end
      $finish;
   end

   initial begin : result_check
      result_type got;
      result_type want;
      int         stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 9);
         repeat (stall) begin
            rsp_bus.ready <= 1'b0;
            @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.next_alive      = rsp_bus.next_alive;
         got.live_neighbours = rsp_bus.live_neighbours;
         got.frame_last      = rsp_bus.frame_last;
         if (pending_states.size() == 0) begin
            report_mismatch($sformatf("result transfer with nothing pending: %b %0d %b",
                                      got.next_alive, got.live_neighbours, got.frame_last));
         end else begin
            want = pending_states.pop_front();
            if (got.next_alive !== want.next_alive)
               report_mismatch($sformatf("next_alive %b, predicted %b",
                                         got.next_alive, want.next_alive));
            if (got.live_neighbours !== want.live_neighbours)
               report_mismatch($sformatf("live_neighbours %0d, predicted %0d",
                                         got.live_neighbours, want.live_neighbours));
            if (got.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %b, predicted %b",
                                         got.frame_last, want.frame_last));
         end
      end
   end

   // no transfer on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles, %0d results pending",
                  idle_cycles, pending_states.size());
         $display("life_generation_stencil: mismatch");
         $finish;
      end
   end

endmodule

// ----- files.f -----
design/lgs_pkg.sv
design/lgs_if.sv
design/lgs_line_cell.sv
design/lgs_rule_stage.sv
design/life_generation_stencil.sv
dv/testbench.sv
